[sv/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// Touch pad press classifier package
// Sizes, register indexes, input modes, event codes and the per-pad role tables
// shared by the classifier and its serial divider.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int PAD_COUNT     = 6;
  localparam int CALIB_SAMPLES = 16;
  localparam int RAW_BITS      = 22;

  localparam int PAD_AW  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W   = RAW_BITS + $clog2(CALIB_SAMPLES);
  localparam int DVS_W   = CNT_W;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 22;
  localparam int CMP_W   = ((RAW_BITS > DELTA_W) ? RAW_BITS : DELTA_W) + 1;
  localparam int IIR_W   = RAW_BITS + 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MASK  = 2'd3;

  localparam logic [21:0] MIN_DELTA_RST  = 22'd100;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd200;
  localparam logic [15:0] LONG_PRESS_RST = 16'd800;
  localparam logic [5:0]  LONG_MASK_RST  = 6'd33;

  // Input modes.
  localparam logic [1:0] MODE_CAL = 2'd0;
  localparam logic [1:0] MODE_FIN = 2'd1;
  localparam logic [1:0] MODE_RUN = 2'd2;

  // Event codes.
  localparam logic [2:0] EV_LIGHT_SCENE = 3'd0;
  localparam logic [2:0] EV_NOISE_PLAY  = 3'd1;
  localparam logic [2:0] EV_NOISE_STOP  = 3'd2;
  localparam logic [2:0] EV_VOLUME_UP   = 3'd3;
  localparam logic [2:0] EV_VOLUME_DOWN = 3'd4;

  // Sound identifiers.
  localparam logic [2:0] SND_NONE    = 3'd0;
  localparam logic [2:0] SND_RAIN    = 3'd1;
  localparam logic [2:0] SND_WIND    = 3'd2;
  localparam logic [2:0] SND_BIRD    = 3'd3;
  localparam logic [2:0] SND_THUNDER = 3'd4;

  localparam logic [1:0] SCENE_LAST = 2'd2;

  // Baseline/6 as a reciprocal multiply; the rounding error of the reciprocal
  // stays within one part in 2^(THR_SHIFT-2) over the whole raw range.
  localparam int THR_SHIFT   = RAW_BITS + 3;
  localparam int THR_RECIP_W = RAW_BITS + 1;
  localparam int THR_PROD_W  = RAW_BITS + THR_RECIP_W;
  localparam logic [THR_RECIP_W-1:0] THR_RECIP =
    THR_RECIP_W'(((64'd1 << THR_SHIFT) + 64'd5) / 64'd6);

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [2:0] short_code(input logic [2:0] pad);
    case (pad)
      3'd0:    short_code = EV_LIGHT_SCENE;
      3'd5:    short_code = EV_NOISE_STOP;
      default: short_code = EV_NOISE_PLAY;
    endcase
  endfunction

  function automatic logic [2:0] long_code(input logic [2:0] pad);
    case (pad)
      3'd0:    long_code = EV_VOLUME_UP;
      3'd5:    long_code = EV_VOLUME_DOWN;
      default: long_code = EV_NOISE_PLAY;
    endcase
  endfunction

  function automatic logic [2:0] pad_sound(input logic [2:0] pad);
    case (pad)
      3'd1:    pad_sound = SND_RAIN;
      3'd2:    pad_sound = SND_WIND;
      3'd3:    pad_sound = SND_BIRD;
      3'd4:    pad_sound = SND_THUNDER;
      default: pad_sound = SND_NONE;
    endcase
  endfunction

endpackage

[sv/tpc_div.sv]
// ----------------------------------------------------------------------------
// Touch pad classifier serial divider
// Restoring divider producing one quotient bit per cycle; used for the
// calibration average.
// ----------------------------------------------------------------------------
module tpc_div
  import tpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [DVS_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the low bits always hold it.
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

[sv/touch_pad_press_classifier.sv]
// Flow: a run sample passes the record read (baseline/6 by reciprocal multiply),
// the touch test and the write-back before its event is presented.
// Throughput: one item at a time; the next transfer is taken once the last item is
// written back, after a 26-step serial divide for a finish with counted samples;
// a dropped item is not held and the input stays ready for the next. An event
// write-back waits while the output register is full and not being taken.
// Reset: synchronous, active low; every pad record reads as zero afterwards.
// ----------------------------------------------------------------------------
// Touch pad press classifier
// Per-pad calibration, baseline tracking and short/long press detection with
// the pad records held in a small synchronous memory (read, modify, write).
// ----------------------------------------------------------------------------
module touch_pad_press_classifier
  import tpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // pad[2:0], raw[24:3], time_ms[56:25], zero fill
  input  logic [1:0]            in_tuser,   // mode[1:0]
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // event_pad[2:0], sound_id[5:3], scene_no[7:6]
  output logic [2:0]            out_tuser,  // event_code[2:0]
  // Configuration channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_EVAL, S_WB} state_t;

  typedef struct packed {
    logic [RAW_BITS-1:0] baseline;
    logic                active;
    logic                long_rep;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   last_time;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
  } ent_t;

  state_t              state_r;

  // Configuration registers.
  logic [21:0]         min_delta_r;
  logic [15:0]         debounce_r;
  logic [15:0]         long_ms_r;
  logic [5:0]          mask_r;

  // Captured item.
  logic [1:0]          mode_r;
  logic [2:0]          pad_r;
  logic [PAD_AW-1:0]   addr_r;
  logic [RAW_BITS-1:0] raw_r;
  logic [TIME_W-1:0]   now_r;

  // Pad record memory.
  ent_t                mem [PAD_COUNT];
  logic [PAD_COUNT-1:0] vld_r;
  ent_t                rd_data_r;
  logic                rd_vld_r;
  ent_t                ent;
  ent_t                wr_ent;
  logic                mem_we;

  logic [RAW_BITS-1:0] q_r;
  logic                touch_r;
  logic                deb_ok_r;
  logic                long_ok_r;
  logic [1:0]          scene_r;

  logic                out_valid_r;
  logic [2:0]          out_pad_r;
  logic [2:0]          out_code_r;
  logic [2:0]          out_sound_r;
  logic [1:0]          out_scene_r;

  logic                in_acc;
  logic                item_ok;
  logic [PAD_AW-1:0]   in_addr;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  div_sts_t            div_sts;
  logic [SUM_W-1:0]    div_quo;

  logic [THR_PROD_W-1:0] thr_prod;
  logic [CMP_W-1:0]    thr;
  logic [CMP_W-1:0]    base_x;
  logic [CMP_W-1:0]    raw_x;
  logic                touch_nxt;
  logic [TIME_W-1:0]   dt_last;
  logic [TIME_W-1:0]   dt_press;
  logic [5:0]          mask_sh;
  logic                lp_bit;
  logic [IIR_W-1:0]    iir;

  logic                emit_req;
  logic [2:0]          emit_code;
  logic                stall;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_addr   = PAD_AW'(in_tdata[2:0]);
  assign item_ok   = (32'(in_tdata[2:0]) < PAD_COUNT) &&
                     (in_tuser == MODE_CAL || in_tuser == MODE_FIN || in_tuser == MODE_RUN);
  assign cfg_ready = 1'b1;

  // A record that has never been written reads as all zeros.
  assign ent = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (in_acc && item_ok) begin
      rd_data_r <= mem[in_addr];
      rd_vld_r  <= vld_r[in_addr];
    end
    if (mem_we) begin
      mem[addr_r] <= wr_ent;
    end
  end

  // Divider launch for the calibration average.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = ent.sum;
    div_divisor  = DVS_W'(ent.count);
    if (state_r == S_READ && mode_r == MODE_FIN && ent.count != '0) begin
      div_start = 1'b1;
    end
  end

  tpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign thr_prod = THR_PROD_W'(ent.baseline) * THR_PROD_W'(THR_RECIP);

  // Touch test and elapsed times.
  always_comb begin
    base_x    = CMP_W'(ent.baseline);
    raw_x     = CMP_W'(raw_r);
    thr       = (CMP_W'(q_r) < CMP_W'(min_delta_r)) ? CMP_W'(min_delta_r) : CMP_W'(q_r);
    touch_nxt = (raw_r != '0) && (ent.baseline != '0) &&
                ((raw_x > base_x + thr) || (raw_x + thr < base_x));
    dt_last   = now_r - ent.last_time;
    dt_press  = now_r - ent.start_time;
  end

  assign mask_sh = mask_r >> pad_r;
  assign lp_bit  = mask_sh[0];
  assign iir     = (IIR_W'(ent.baseline) << 5) - IIR_W'(ent.baseline) + IIR_W'(raw_r);

  // Record update and event decision.
  always_comb begin
    wr_ent    = ent;
    emit_req  = 1'b0;
    emit_code = EV_LIGHT_SCENE;
    case (mode_r)
      MODE_CAL: begin
        if (raw_r != '0 && 32'(ent.count) < CALIB_SAMPLES) begin
          wr_ent.sum   = ent.sum + SUM_W'(raw_r);
          wr_ent.count = ent.count + CNT_W'(1);
        end
      end
      MODE_FIN: begin
        wr_ent.baseline = q_r;
        wr_ent.sum      = '0;
        wr_ent.count    = '0;
      end
      MODE_RUN: begin
        if (touch_r && !ent.active && deb_ok_r) begin
          wr_ent.active     = 1'b1;
          wr_ent.long_rep   = 1'b0;
          wr_ent.start_time = now_r;
        end else if (touch_r && ent.active && lp_bit && !ent.long_rep && long_ok_r) begin
          wr_ent.long_rep  = 1'b1;
          wr_ent.last_time = now_r;
          emit_req         = 1'b1;
          emit_code        = long_code(pad_r);
        end else if (!touch_r) begin
          if (ent.active && !ent.long_rep) begin
            wr_ent.last_time = now_r;
            emit_req         = 1'b1;
            emit_code        = short_code(pad_r);
          end
          wr_ent.active     = 1'b0;
          wr_ent.long_rep   = 1'b0;
          wr_ent.start_time = '0;
          if (raw_r != '0 && ent.baseline != '0) begin
            wr_ent.baseline = RAW_BITS'(iir >> 5);
          end
        end
      end
      default: begin
        wr_ent = ent;
      end
    endcase
  end

  assign stall  = emit_req && out_valid_r && !out_tready;
  assign mem_we = (state_r == S_WB) && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      scene_r     <= '0;
      out_valid_r <= 1'b0;
      min_delta_r <= MIN_DELTA_RST;
      debounce_r  <= DEBOUNCE_RST;
      long_ms_r   <= LONG_PRESS_RST;
      mask_r      <= LONG_MASK_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_DELTA:  min_delta_r <= cfg_data[21:0];
          REG_DEBOUNCE:   debounce_r  <= cfg_data[15:0];
          REG_LONG_PRESS: long_ms_r   <= cfg_data[15:0];
          REG_LONG_MASK:  mask_r      <= cfg_data[5:0];
          default:        mask_r      <= mask_r;
        endcase
      end

      // The register empties on a transfer unless a new event loads it.
      if (out_tready && !(mem_we && emit_req)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && item_ok) begin
            mode_r  <= in_tuser;
            pad_r   <= in_tdata[2:0];
            addr_r  <= in_addr;
            raw_r   <= RAW_BITS'(in_tdata[24:3]);
            now_r   <= in_tdata[56:25];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (mode_r == MODE_RUN) begin
            q_r     <= RAW_BITS'(thr_prod >> THR_SHIFT);
            state_r <= S_EVAL;
          end else begin
            q_r     <= '0;
            state_r <= div_start ? S_DIV : S_WB;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            q_r     <= RAW_BITS'(div_quo);
            state_r <= (mode_r == MODE_RUN) ? S_EVAL : S_WB;
          end
        end
        S_EVAL: begin
          touch_r   <= touch_nxt;
          deb_ok_r  <= (dt_last >= TIME_W'(debounce_r));
          long_ok_r <= (dt_press >= TIME_W'(long_ms_r));
          state_r   <= S_WB;
        end
        S_WB: begin
          // Hold the write-back until the output register can take the event.
          if (!stall) begin
            vld_r[addr_r] <= 1'b1;
            state_r       <= S_IDLE;
            if (emit_req) begin
              out_valid_r <= 1'b1;
              out_pad_r   <= pad_r;
              out_code_r  <= emit_code;
              out_sound_r <= pad_sound(pad_r);
              out_scene_r <= (emit_code == EV_LIGHT_SCENE) ? scene_r : 2'd0;
              if (emit_code == EV_LIGHT_SCENE) begin
                scene_r <= (scene_r == SCENE_LAST) ? 2'd0 : scene_r + 2'd1;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_scene_r, out_sound_r, out_pad_r};
  assign out_tuser  = out_code_r;

  a_scene_range: assert property (@(posedge clk) disable iff (!rst_n)
    scene_r != 2'd3)
    else $error("scene counter left its three-value cycle");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_sts.busy || div_sts.done)
    else $error("waiting on a divider that is not running");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && item_ok |=> state_r == S_READ)
    else $error("accepted item did not start a record read");

  a_event_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r)
    else $error("pending event dropped before transfer");

endmodule
